### rtl/core/gbf_pkg.sv
// Shared types and constants for the grid BFS flow field block.
`default_nettype none

package gbf_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    localparam int REG_W = 7;
    localparam logic [REG_W-1:0] GRID_W_RESET = 7'd16;
    localparam logic [REG_W-1:0] GRID_H_RESET = 7'd16;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_RECOMP = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [2:0] DIR_NONE = 3'd0;

    localparam int COST_MAX = 4095;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic       walkable;
    } req_t;

    typedef struct packed {
        logic        path_clear;
        logic [2:0]  direction;
        logic        reachable;
        logic [11:0] cost;
    } res_t;

endpackage

`default_nettype wire

### rtl/core/gbf_nbr.sv
// Neighbor address and bounds check for one of the four step directions.
`default_nettype none

module gbf_nbr #(
    parameter int XW = 6,
    parameter int YW = 6
) (
    input  wire logic [XW+YW-1:0] center,
    input  wire logic [1:0]       dir,
    input  wire logic [XW-1:0]    wmax,
    input  wire logic [YW-1:0]    hmax,
    output logic                  ok,
    output logic [XW+YW-1:0]      naddr
);

    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    logic [XW-1:0] nx;
    logic [YW-1:0] ny;

    assign cx = center[XW-1:0];
    assign cy = center[XW+YW-1:XW];

    always_comb
    begin
        nx = cx;
        ny = cy;
        ok = 1'b0;
        case (dir)
            2'd0:
            begin
                ok = (cy != hmax);
                ny = cy + YW'(1);
            end
            2'd1:
            begin
                ok = (cy != '0);
                ny = cy - YW'(1);
            end
            2'd2:
            begin
                ok = (cx != wmax);
                nx = cx + XW'(1);
            end
            default:
            begin
                ok = (cx != '0);
                nx = cx - XW'(1);
            end
        endcase
    end

    assign naddr = {ny, nx};

endmodule

`default_nettype wire

### rtl/core/gbf_engine.sv
// Map memories and the search / direction / query sequencer.
`default_nettype none

module gbf_engine #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire gbf_pkg::req_t               req,
    input  wire logic [$clog2(MAX_COLS)-1:0] wmax,
    input  wire logic [$clog2(MAX_ROWS)-1:0] hmax,
    output logic                             idle,
    output logic                             done,
    output gbf_pkg::res_t                    res
);
    import gbf_pkg::*;

    localparam int XW    = $clog2(MAX_COLS);
    localparam int YW    = $clog2(MAX_ROWS);
    localparam int AW    = XW + YW;
    localparam int CW    = AW + 1;
    localparam int CDW   = CW + 3;
    localparam int CELLS = 1 << AW;

    typedef enum logic [17:0] {
        S_CLEAR  = 18'b000000000000000001,
        S_IDLE   = 18'b000000000000000010,
        S_WIPE   = 18'b000000000000000100,
        S_SEED   = 18'b000000000000001000,
        S_POP    = 18'b000000000000010000,
        S_CUR    = 18'b000000000000100000,
        S_CCOST  = 18'b000000000001000000,
        S_NREQ   = 18'b000000000010000000,
        S_NEVAL  = 18'b000000000100000000,
        S_DREAD  = 18'b000000001000000000,
        S_DCHK   = 18'b000000010000000000,
        S_DNREQ  = 18'b000000100000000000,
        S_DNEVAL = 18'b000001000000000000,
        S_DWR    = 18'b000010000000000000,
        S_DNEXT  = 18'b000100000000000000,
        S_QOUT   = 18'b001000000000000000,
        S_PC     = 18'b010000000000000000,
        S_PCOUT  = 18'b100000000000000000
    } state_t;

    localparam logic [CW-1:0] UNREACHED = '1;

    state_t state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW:0]   head_reg, head_next;
    logic [AW:0]   tail_reg, tail_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] nb_reg, nb_next;
    logic [CW-1:0] cost_reg, cost_next;
    logic [CW-1:0] best_reg, best_next;
    logic [2:0]    code_reg, code_next;
    logic [1:0]    d_reg, d_next;

    logic [CDW-1:0] cd_mem [CELLS];
    logic           walk_mem [CELLS];
    logic [AW-1:0]  q_mem [CELLS];

    logic           cd_we, walk_we, q_we;
    logic [AW-1:0]  cd_wa, cd_ra, walk_wa, walk_ra, q_wa;
    logic [CDW-1:0] cd_wd, cd_rd;
    logic           walk_wd, walk_rd;
    logic [AW-1:0]  q_wd, q_rd;

    logic           nb_ok;
    logic [AW-1:0]  nb_addr;
    logic [AW-1:0]  goal;
    logic [XW-1:0]  qx;
    logic [YW-1:0]  qy;
    logic [CW-1:0]  rd_cost;

    assign goal    = {hmax, wmax};
    assign rd_cost = cd_rd[CDW-1:3];
    assign qx      = (32'(req.cell_x) > 32'(wmax)) ? wmax : XW'(req.cell_x);
    assign qy      = (32'(req.cell_y) > 32'(hmax)) ? hmax : YW'(req.cell_y);

    gbf_nbr #(.XW(XW), .YW(YW)) u_nbr (
        .center (cur_reg),
        .dir    (d_reg),
        .wmax   (wmax),
        .hmax   (hmax),
        .ok     (nb_ok),
        .naddr  (nb_addr)
    );

    always_ff @(posedge clk)
    begin
        if (cd_we)
            cd_mem[cd_wa] <= cd_wd;
        cd_rd <= cd_mem[cd_ra];
    end

    always_ff @(posedge clk)
    begin
        if (walk_we)
            walk_mem[walk_wa] <= walk_wd;
        walk_rd <= walk_mem[walk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_wa] <= q_wd;
        q_rd <= q_mem[head_reg[AW-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cur_next   = cur_reg;
        nb_next    = nb_reg;
        cost_next  = cost_reg;
        best_next  = best_reg;
        code_next  = code_reg;
        d_next     = d_reg;
        cd_we      = 1'b0;
        cd_wa      = cnt_reg;
        cd_wd      = {UNREACHED, DIR_NONE};
        cd_ra      = nb_addr;
        walk_we    = 1'b0;
        walk_wa    = cnt_reg;
        walk_wd    = 1'b1;
        walk_ra    = nb_addr;
        q_we       = 1'b0;
        q_wa       = tail_reg[AW-1:0];
        q_wd       = nb_reg;
        done       = 1'b0;
        res        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cd_we   = 1'b1;
                walk_we = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == '1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cd_ra = {qy, qx};
                if (start)
                begin
                    case (req.command)
                        CMD_WRITE:
                        begin
                            walk_we = (32'(req.cell_x) < MAX_COLS) &&
                                      (32'(req.cell_y) < MAX_ROWS);
                            walk_wa = {YW'(req.cell_y), XW'(req.cell_x)};
                            walk_wd = req.walkable;
                            done    = 1'b1;
                        end
                        CMD_RECOMP:
                        begin
                            cnt_next   = '0;
                            state_next = S_WIPE;
                        end
                        CMD_QUERY:
                            state_next = S_QOUT;
                        default:
                            done = 1'b1;
                    endcase
                end
            end
            S_WIPE:
            begin
                cd_we    = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == '1)
                    state_next = S_SEED;
            end
            S_SEED:
            begin
                cd_we      = 1'b1;
                cd_wa      = goal;
                cd_wd      = {CW'(0), DIR_NONE};
                q_we       = 1'b1;
                q_wa       = '0;
                q_wd       = goal;
                head_next  = '0;
                tail_next  = (AW+1)'(1);
                state_next = S_POP;
            end
            S_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    cur_next   = '0;
                    state_next = S_DREAD;
                end
                else
                begin
                    head_next  = head_reg + (AW+1)'(1);
                    state_next = S_CUR;
                end
            end
            S_CUR:
            begin
                cur_next   = q_rd;
                cd_ra      = q_rd;
                state_next = S_CCOST;
            end
            S_CCOST:
            begin
                cost_next  = rd_cost + CW'(1);
                d_next     = 2'd0;
                state_next = S_NREQ;
            end
            S_NREQ:
            begin
                nb_next = nb_addr;
                if (nb_ok)
                    state_next = S_NEVAL;
                else if (d_reg == 2'd3)
                    state_next = S_POP;
                else
                    d_next = d_reg + 2'd1;
            end
            S_NEVAL:
            begin
                if (walk_rd && (rd_cost > cost_reg))
                begin
                    cd_we     = 1'b1;
                    cd_wa     = nb_reg;
                    cd_wd     = {cost_reg, DIR_NONE};
                    q_we      = 1'b1;
                    tail_next = tail_reg + (AW+1)'(1);
                end
                if (d_reg == 2'd3)
                    state_next = S_POP;
                else
                begin
                    d_next     = d_reg + 2'd1;
                    state_next = S_NREQ;
                end
            end
            S_DREAD:
            begin
                cd_ra      = cur_reg;
                state_next = S_DCHK;
            end
            S_DCHK:
            begin
                cost_next = rd_cost;
                best_next = rd_cost;
                code_next = DIR_NONE;
                d_next    = 2'd0;
                if ((rd_cost == UNREACHED) || (rd_cost == '0))
                    state_next = S_DNEXT;
                else
                    state_next = S_DNREQ;
            end
            S_DNREQ:
            begin
                if (nb_ok)
                    state_next = S_DNEVAL;
                else if (d_reg == 2'd3)
                    state_next = S_DWR;
                else
                    d_next = d_reg + 2'd1;
            end
            S_DNEVAL:
            begin
                if (walk_rd && (rd_cost < best_reg))
                begin
                    best_next = rd_cost;
                    code_next = {1'b0, d_reg} + 3'd1;
                end
                if (d_reg == 2'd3)
                    state_next = S_DWR;
                else
                begin
                    d_next     = d_reg + 2'd1;
                    state_next = S_DNREQ;
                end
            end
            S_DWR:
            begin
                cd_we      = 1'b1;
                cd_wa      = cur_reg;
                cd_wd      = {cost_reg, code_reg};
                state_next = S_DNEXT;
            end
            S_DNEXT:
            begin
                state_next = S_DREAD;
                if (cur_reg[XW-1:0] == wmax)
                begin
                    if (cur_reg[AW-1:XW] == hmax)
                        state_next = S_PC;
                    else
                        cur_next = {cur_reg[AW-1:XW] + YW'(1), XW'(0)};
                end
                else
                    cur_next = {cur_reg[AW-1:XW], cur_reg[XW-1:0] + XW'(1)};
            end
            S_QOUT:
            begin
                done          = 1'b1;
                res.reachable = (rd_cost != UNREACHED);
                if (rd_cost != UNREACHED)
                    res.cost = (32'(rd_cost) > COST_MAX) ? 12'(COST_MAX) : 12'(rd_cost);
                res.direction = cd_rd[2:0];
                state_next    = S_IDLE;
            end
            S_PC:
            begin
                cd_ra      = '0;
                state_next = S_PCOUT;
            end
            S_PCOUT:
            begin
                done           = 1'b1;
                res.path_clear = (rd_cost != UNREACHED);
                state_next     = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        nb_reg   <= nb_next;
        cost_reg <= cost_next;
        best_reg <= best_next;
        code_reg <= code_next;
        d_reg    <= d_next;
    end

    assign idle = (state_reg == S_IDLE);

    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == S_IDLE))
        else $error("command started while busy");

    a_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEED) |=> (head_reg == '0) && (tail_reg == (AW+1)'(1)))
        else $error("queue not seeded with goal");

    a_pc_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PCOUT) |-> done && !res.reachable)
        else $error("recompute result malformed");

endmodule

`default_nettype wire

### rtl/core/grid_bfs_flow_field.sv
// Write and unknown commands complete on acceptance; a query first reads the cost/direction memory.
// Recompute: a wipe pass over all 2^AW cells (4096 at 64x64), then a search pass over each
//   reached cell and its in-grid neighbors, then a direction pass over every grid cell that
//   checks neighbors of cells reached at nonzero cost, via the single cost/direction read port.
// One command is in flight at a time; the next is taken once the result is accepted.
// Reset: a clearing pass over all 2^AW cells sets every cell walkable and unreached.
`default_nettype none

module grid_bfs_flow_field #(
    parameter int MAX_COLS = gbf_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gbf_pkg::DEF_MAX_ROWS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic                      cfg_index,
    input  wire logic [gbf_pkg::REG_W-1:0] cfg_data,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [15:0]               s_tdata,  // cell_x, cell_y, walkable
    input  wire logic [1:0]                s_tuser,  // command
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [23:0]                    m_tdata   // cost, reachable, direction, path_clear
);
    import gbf_pkg::*;

    localparam int XW = $clog2(MAX_COLS);
    localparam int YW = $clog2(MAX_ROWS);

    logic [REG_W-1:0] gw_reg, gh_reg;
    logic [XW-1:0]    wmax;
    logic [YW-1:0]    hmax;
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg;
    res_t             eng_res;
    req_t             req;
    logic             eng_idle, eng_done, start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= GRID_W_RESET;
            gh_reg <= GRID_H_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_GRID_WIDTH)
                gw_reg <= cfg_data;
            else
                gh_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (gw_reg == '0)
            wmax = '0;
        else if (32'(gw_reg) > MAX_COLS)
            wmax = XW'(MAX_COLS - 1);
        else
            wmax = XW'(gw_reg - REG_W'(1));
        if (gh_reg == '0)
            hmax = '0;
        else if (32'(gh_reg) > MAX_ROWS)
            hmax = YW'(MAX_ROWS - 1);
        else
            hmax = YW'(gh_reg - REG_W'(1));
    end

    assign req.command  = s_tuser;
    assign req.cell_x   = s_tdata[5:0];
    assign req.cell_y   = s_tdata[11:6];
    assign req.walkable = s_tdata[12];

    assign s_tready = eng_idle && (!out_valid_reg || m_tready);
    assign start    = s_tvalid && s_tready;

    gbf_engine #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .wmax  (wmax),
        .hmax  (hmax),
        .idle  (eng_idle),
        .done  (eng_done),
        .res   (eng_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (eng_done)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (eng_done)
            out_reg <= eng_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg};

endmodule

`default_nettype wire
